// ===== hw/rtl/psev_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Beat types, operation and status codes, and the controller state type
// shared by the evaluator's modules.
// ----------------------------------------------------------------------------
package psev_pkg;

    // Field widths fixed by the beat formats.
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_NEG  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DUP  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDER  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVER   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_HALTED = 2'd3;

    // Saturation bounds in Q16.16.
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // Input beat.
    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] push_value;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] top_value;
        logic [COUNT_W-1:0]        stack_count;
        logic                      saturated;
    } t_out_item;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_psev_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_psev_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/psev_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module psev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire [WIDTH-1:0]           i_wr_data,
    input  wire [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/psev_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix stack evaluator controller
// Takes an input beat when the result register is free, then enters the
// execute state, which commands the datapath to execute the operation.
// ----------------------------------------------------------------------------
module psev_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  psev_pkg::t_psev_stat  i_stat,
    output psev_pkg::t_psev_cmd   o_cmd
);
    import psev_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.out_free) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = i_stat.out_free;
                o_cmd.capture = i_in_valid && i_stat.out_free;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/psev_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix stack evaluator datapath
// Holds the top of stack in a register and the deeper entries in a RAM,
// performs the operation, and keeps the result register.
// ----------------------------------------------------------------------------
module psev_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  psev_pkg::t_in_item    i_in_item,
    input  psev_pkg::t_psev_cmd   i_cmd,
    output psev_pkg::t_psev_stat  o_stat,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output psev_pkg::t_out_item   o_out_item
);
    import psev_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Captured operation.
    logic [OPCODE_W-1:0]       r_op;
    logic signed [VALUE_W-1:0] r_pv;

    // Stack state.
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic signed [VALUE_W-1:0] r_top;
    logic signed [VALUE_W-1:0] n_top;
    logic                      r_halted;
    logic                      n_halted;

    // Result register.
    logic                      r_out_valid;
    t_out_item                 r_out_item;
    t_out_item                 n_out_item;

    // RAM access.
    logic                      wr_en;
    logic [CW-1:0]             cnt_m1;
    logic [CW-1:0]             cnt_m2;
    logic signed [VALUE_W-1:0] second;
    logic signed [VALUE_W:0]   sum_ext;
    logic [STATUS_W-1:0]       status;
    logic                      sat;

    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);

    // Entries below the top live in the RAM; the second entry is read
    // continuously so it is ready in the execute cycle.
    psev_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (cnt_m1[AW-1:0]),
        .i_wr_data (r_top),
        .i_rd_addr (cnt_m2[AW-1:0]),
        .o_rd_data (second)
    );

    // Sum or difference with one guard bit.
    always_comb begin
        if (r_op == OP_SUB) begin
            sum_ext = {second[VALUE_W-1], second} - {r_top[VALUE_W-1], r_top};
        end else begin
            sum_ext = {second[VALUE_W-1], second} + {r_top[VALUE_W-1], r_top};
        end
    end

    // Operation decode and next stack state.
    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_halted = r_halted;
        status   = STAT_OK;
        sat      = 1'b0;
        wr_en    = 1'b0;
        if (r_halted) begin
            status = STAT_HALTED;
        end else begin
            case (r_op) inside
                OP_PUSH, OP_DUP: begin
                    if (r_op == OP_DUP && r_count == '0) begin
                        status = STAT_UNDER;
                    end else if (r_count >= CW'(STACK_DEPTH)) begin
                        status = STAT_OVER;
                    end else begin
                        // Spill the old top into the RAM.
                        wr_en   = i_cmd.execute && (r_count != '0);
                        n_count = r_count + CW'(1);
                        if (r_op == OP_PUSH) begin
                            n_top = r_pv;
                        end
                    end
                end
                OP_ADD, OP_SUB: begin
                    if (r_count < CW'(2)) begin
                        status = STAT_UNDER;
                    end else begin
                        n_count = cnt_m1;
                        if (sum_ext[VALUE_W] != sum_ext[VALUE_W-1]) begin
                            sat   = 1'b1;
                            n_top = sum_ext[VALUE_W] ? VALUE_MIN : VALUE_MAX;
                        end else begin
                            n_top = sum_ext[VALUE_W-1:0];
                        end
                    end
                end
                OP_NEG: begin
                    if (r_count == '0) begin
                        status = STAT_UNDER;
                    end else if (r_top == VALUE_MIN) begin
                        sat   = 1'b1;
                        n_top = VALUE_MAX;
                    end else begin
                        n_top = -r_top;
                    end
                end
                default: begin
                    status = STAT_OK;
                end
            endcase
            if (status == STAT_UNDER || status == STAT_OVER) begin
                n_halted = 1'b1;
            end
        end
        n_out_item.status      = status;
        n_out_item.top_value   = (n_count != '0) ? n_top : '0;
        n_out_item.stack_count = COUNT_W'(n_count);
        n_out_item.saturated   = sat;
    end

    // Captured beat and payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_in_item.opcode;
            r_pv <= i_in_item.push_value;
        end
        if (i_cmd.execute) begin
            r_top      <= n_top;
            r_out_item <= n_out_item;
        end
    end

    // Control state: depth, halt flag and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_count     <= n_count;
                r_halted    <= n_halted;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

`ifndef ASSERT_OFF
    // The depth never passes the stack size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack depth beyond the stack size");

    // Once halted, only reset clears the flag.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |-> !r_out_valid)
        else $error("result register overwritten");

    // A halted block reports every beat as ignored and leaves the depth.
    a_halted_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && i_cmd.execute) |=>
            (r_out_item.status == STAT_HALTED) && $stable(r_count))
        else $error("beat not ignored while halted");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/postfix_stack_evaluator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Q16.16 postfix stack machine: push, add, subtract, negate, duplicate.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid, o_in_ready, i_in_item) carries one
// operation per beat; the output channel (o_out_valid, i_out_ready,
// o_out_item) returns one result beat per operation, in order, with the
// status, the new top of stack, the depth and the saturation flag.
// Each operation takes a capture step and then an execute step; the result
// beat is registered in the execute step, which uses the second entry from
// the registered read port of the stack RAM; the top entry sits in a register.
// No new beat is taken while an operation is in its execute step.
// If the receiver stalls, the result waits in the output register and no
// new beat is taken until that register is free or being emptied.
// An underflow or overflow halts the block: later beats are answered with
// the ignored status until reset. Synchronous reset empties the stack,
// clears the halt and drops any pending result; the stack RAM is not
// cleared, as entries are only read after being written.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  psev_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output psev_pkg::t_out_item  o_out_item
);
    import psev_pkg::*;

    t_psev_cmd  cmd;
    t_psev_stat stat;

    // Sequencing of capture and execute.
    psev_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Stack storage, arithmetic and result register.
    psev_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Postfix stack evaluator testbench
// Drives push, add, subtract, negate, duplicate and unused operation codes
// into the evaluator, predicts every result beat with a bit-accurate Q16.16
// stack model, and checks each result beat field by field, in order. Both
// channels idle in random bursts. The run finishes by forcing an underflow
// or an overflow and then checks that the block ignores the remaining beats.
// ----------------------------------------------------------------------------
module testbench;
    import psev_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int RANDOM_OPS  = 1650;
    localparam int IGNORED_OPS = 24;
    localparam int QUIET_TAIL  = 150;

    // Operation codes that the block treats as no operation.
    localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct {
        t_in_item beat;
        bit       drain_first;
    } t_queued_op;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Operations waiting to be sent, and results waiting to be seen.
    t_queued_op op_queue[$];
    t_out_item  predicted_results[$];

    // Stack model that follows the accepted operations.
    logic signed [VALUE_W-1:0] model_stack [STACK_DEPTH];
    int unsigned               model_depth  = 0;
    bit                        model_halted = 1'b0;

    // Depth seen by the stimulus generator while it plans the sequence.
    int unsigned gen_depth   = 0;
    bit          drain_next  = 1'b0;
    int          total_ops   = 0;
    string       stop_reason = "";

    int sent_count     = 0;
    int received_count = 0;
    int fail_count     = 0;
    int clamp_count    = 0;
    int deepest        = 0;

    int src_gap       = 0;
    int src_idle_pct  = 0;
    int sink_gap      = 0;
    int sink_idle_pct = 0;
    int drv_cycles    = 0;
    int mon_cycles    = 0;

    postfix_stack_evaluator_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Clamp a wide sum to the Q16.16 range and flag whether it was clamped.
    function automatic logic signed [VALUE_W-1:0] clamp_q16(input longint v,
                                                            output bit clamped);
        clamped = 1'b1;
        if (v > longint'(VALUE_MAX)) return VALUE_MAX;
        if (v < longint'(VALUE_MIN)) return VALUE_MIN;
        clamped = 1'b0;
        return v[VALUE_W-1:0];
    endfunction

    // Apply one operation to the stack model and return its result beat.
    function t_out_item evaluate_op(input t_in_item beat);
        t_out_item res;
        longint    top_v;
        longint    second_v;
        bit        clamped;
        res        = '0;
        res.status = STAT_OK;
        clamped    = 1'b0;
        if (model_halted) begin
            res.status = STAT_HALTED;
        end else begin
            case (beat.opcode)
                OP_PUSH, OP_DUP: begin
                    if (beat.opcode == OP_DUP && model_depth == 0) begin
                        res.status = STAT_UNDER;
                    end else if (model_depth >= STACK_DEPTH) begin
                        res.status = STAT_OVER;
                    end else begin
                        model_stack[model_depth] = (beat.opcode == OP_PUSH) ?
                            beat.push_value : model_stack[model_depth-1];
                        model_depth++;
                    end
                end
                OP_ADD, OP_SUB: begin
                    if (model_depth < 2) begin
                        res.status = STAT_UNDER;
                    end else begin
                        top_v    = longint'(model_stack[model_depth-1]);
                        second_v = longint'(model_stack[model_depth-2]);
                        model_stack[model_depth-2] = clamp_q16(
                            (beat.opcode == OP_ADD) ? second_v + top_v
                                                    : second_v - top_v,
                            clamped);
                        model_depth--;
                    end
                end
                OP_NEG: begin
                    if (model_depth == 0) begin
                        res.status = STAT_UNDER;
                    end else begin
                        top_v = longint'(model_stack[model_depth-1]);
                        model_stack[model_depth-1] = clamp_q16(-top_v, clamped);
                    end
                end
                default: ;
            endcase
            if (res.status == STAT_UNDER || res.status == STAT_OVER) begin
                model_halted = 1'b1;
            end
        end
        res.top_value   = (model_depth > 0) ? model_stack[model_depth-1] : '0;
        res.stack_count = model_depth[COUNT_W-1:0];
        res.saturated   = clamped;
        return res;
    endfunction

    // Values biased towards the saturation bounds and zero.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] offset;
        offset = $urandom_range(0, 32'h0004_0000);
        case ($urandom_range(0, 7))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return '0;
            3: return offset - 32'sh0002_0000;
            4: return VALUE_MAX - offset;
            5: return VALUE_MIN + offset;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 4;
            2: return 12;
            default: return 30;
        endcase
    endfunction

    // Append one operation to the send queue and track the planned depth.
    task automatic queue_op(input logic [OPCODE_W-1:0] op,
                            input logic signed [VALUE_W-1:0] value);
        t_queued_op entry;
        entry.beat.opcode     = op;
        entry.beat.push_value = value;
        entry.drain_first     = drain_next;
        drain_next            = 1'b0;
        op_queue.insert(op_queue.size(), entry);
        total_ops++;
        if ((op == OP_PUSH || op == OP_DUP) && gen_depth < STACK_DEPTH) begin
            gen_depth++;
        end else if ((op == OP_ADD || op == OP_SUB) && gen_depth >= 2) begin
            gen_depth--;
        end
    endtask

    // Compare one field and report it if it differs.
    task automatic report_field(input string field, input longint want,
                                input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Check a result beat against the oldest prediction.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (predicted_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result beat, expected none, actual %h",
                     $time, got);
        end else begin
            want = predicted_results.pop_front();
            report_field("status", want.status, got.status);
            report_field("top_value", want.top_value, got.top_value);
            report_field("stack_count", want.stack_count, got.stack_count);
            report_field("saturated", want.saturated, got.saturated);
            if (want.saturated) clamp_count++;
            if (int'(want.stack_count) > deepest) deepest = int'(want.stack_count);
        end
    endtask

    // Operation driver: holds each beat until it is taken.
    always @(posedge clk) begin : drive_ops
        bit hold;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            hold = in_valid && !in_ready;
            if (in_valid && in_ready) begin
                predicted_results.insert(predicted_results.size(),
                                         evaluate_op(in_item));
                sent_count++;
                op_queue.delete(0);
            end
            drv_cycles++;
            if (drv_cycles % 64 == 0) begin
                src_idle_pct = pick_idle_pct();
            end
            if (!hold) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (op_queue.size() >= QUIET_TAIL &&
                             $urandom_range(0, 99) < src_idle_pct) begin
                    src_gap = $urandom_range(0, 14);
                    in_valid <= 1'b0;
                end else if (op_queue.size() > 0 && (!op_queue[0].drain_first ||
                             received_count == sent_count)) begin
                    in_valid <= 1'b1;
                    in_item  <= op_queue[0].beat;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk) begin : watch_results
        bit quiet;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                check_result(out_item);
                received_count <= received_count + 1;
            end
            mon_cycles++;
            quiet = (total_ops - received_count) < QUIET_TAIL;
            if (mon_cycles % 64 == 0) begin
                sink_idle_pct = pick_idle_pct();
            end
            if (sink_gap > 0) begin
                sink_gap--;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap = $urandom_range(0, 14);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin : run_sequence
        int target;
        int roll;
        logic [OPCODE_W-1:0] op;

        // Saturating sums, negating the most negative value, and zero.
        queue_op(OP_PUSH, VALUE_MAX);
        queue_op(OP_PUSH, 32'sh0001_0000);
        queue_op(OP_ADD, pick_value());
        queue_op(OP_PUSH, VALUE_MIN);
        queue_op(OP_NEG, pick_value());
        queue_op(OP_PUSH, VALUE_MIN);
        queue_op(OP_PUSH, 32'sh0000_0001);
        queue_op(OP_SUB, pick_value());
        queue_op(OP_PUSH, -32'sd1);
        queue_op(OP_ADD, pick_value());
        queue_op(OP_DUP, pick_value());
        queue_op(OP_SUB, pick_value());
        queue_op(OP_NEG, pick_value());
        for (op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST && op >= OP_UNUSED_FIRST;
             op++) begin
            queue_op(op, pick_value());
        end
        queue_op(OP_PUSH, VALUE_MAX);
        queue_op(OP_PUSH, -32'sd1);
        queue_op(OP_SUB, pick_value());

        // Random walk of the depth towards a target that changes now and then,
        // never letting the stack underflow or overflow.
        target = 0;
        for (int k = 0; k < RANDOM_OPS; k++) begin
            if (k % 40 == 0) target = $urandom_range(0, STACK_DEPTH);
            if (k == RANDOM_OPS / 3 || k == 2 * RANDOM_OPS / 3) drain_next = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                op = OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            end else if (roll < 16 && gen_depth >= 1) begin
                op = OP_NEG;
            end else if (gen_depth < target || gen_depth < 2) begin
                op = (gen_depth >= 1 && $urandom_range(0, 3) == 0) ? OP_DUP : OP_PUSH;
            end else begin
                op = $urandom_range(0, 1) ? OP_ADD : OP_SUB;
            end
            queue_op(op, pick_value());
        end

        // Wait for all results, then force a halt and check it sticks.
        drain_next = 1'b1;
        if ($urandom_range(0, 1)) begin
            stop_reason = "overflow";
            while (gen_depth < STACK_DEPTH) queue_op(OP_PUSH, pick_value());
            queue_op($urandom_range(0, 1) ? OP_PUSH : OP_DUP, pick_value());
        end else begin
            stop_reason = "underflow";
            while (gen_depth > 1) queue_op(OP_ADD, pick_value());
            queue_op($urandom_range(0, 1) ? OP_ADD : OP_SUB, pick_value());
        end
        for (int k = 0; k < IGNORED_OPS; k++) begin
            queue_op(OPCODE_W'($urandom_range(OP_PUSH, OP_UNUSED_LAST)), pick_value());
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() > 0 || received_count != sent_count) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (predicted_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d result beats never arrived", $time,
                     predicted_results.size());
        end

        $display("Checked %0d result beats; %0d clamped sums, deepest stack %0d.",
                 received_count, clamp_count, deepest);
        $display("The run ended with a forced %s and %0d ignored operations.",
                 stop_reason, IGNORED_OPS);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
